// ===== src/slip_leg_phase_and_spring_force_unit_defines.svh =====
// assertion macros for the checker file
`ifndef SLIP_LEG_PHASE_AND_SPRING_FORCE_UNIT_DEFINES_SVH
`define SLIP_LEG_PHASE_AND_SPRING_FORCE_UNIT_DEFINES_SVH

// same-cycle implication under reset
`define SLPSF_AST_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define SLPSF_AST_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/slpsf_pkg.sv =====
// shared widths, codes and types of the slip leg unit
package slpsf_pkg;

    localparam int CfgW     = 21;
    localparam int KW       = 16;
    localparam int WordW    = 32;
    localparam int MulW     = 34;
    localparam int ProdW    = 68;
    localparam int SrcW     = 84;
    localparam int RemW     = 36;
    localparam int CntW     = 7;
    localparam int SqrtSteps = 34;
    localparam int DivSteps  = 84;

    // register indexes
    localparam logic [1:0] REG_REST_LEN  = 2'd0;
    localparam logic [1:0] REG_STIFF     = 2'd1;
    localparam logic [1:0] REG_TD_HEIGHT = 2'd2;
    localparam logic [1:0] REG_REACH     = 2'd3;

    // velocity sign codes
    localparam logic [1:0] SIGN_NEG  = 2'b11;
    localparam logic [1:0] SIGN_ZERO = 2'b00;
    localparam logic [1:0] SIGN_POS  = 2'b01;

    typedef struct packed {
        logic start;
        logic is_sqrt;
    } rsu_ctrl_t;

endpackage

// ===== src/slpsf_mul.sv =====
// shared registered 34x34 unsigned multiplier
module slpsf_mul
    import slpsf_pkg::*;
(
    input  logic             clk,
    input  logic [MulW-1:0]  a,
    input  logic [MulW-1:0]  b,
    output logic [ProdW-1:0] p
);

    logic [ProdW-1:0] p_reg;

    // product register
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// ===== src/slpsf_rsu.sv =====
// restoring compare-subtract unit for square root and division
module slpsf_rsu
    import slpsf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  rsu_ctrl_t       ctrl,
    input  logic [SrcW-1:0] src,
    input  logic [MulW-1:0] dvsr,
    output logic            done,
    output logic [SrcW-1:0] quo
);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic            sqrt_reg, sqrt_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [SrcW-1:0] src_reg, src_next;
    logic [RemW-1:0] rem_reg, rem_next;
    logic [SrcW-1:0] q_reg, q_next;
    logic [RemW-1:0] rem_sh, trial, diff;
    logic            geq;

    // one digit step: shift in, trial subtract
    always_comb
    begin
        if (sqrt_reg)
        begin
            rem_sh = {rem_reg[RemW-3:0], src_reg[SrcW-1 -: 2]};
            trial  = {q_reg[RemW-3:0], 2'b01};
        end
        else
        begin
            rem_sh = {rem_reg[RemW-2:0], src_reg[SrcW-1]};
            trial  = {{(RemW-MulW){1'b0}}, dvsr};
        end
        geq  = (rem_sh >= trial);
        diff = rem_sh - trial;
    end

    // step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sqrt_next = sqrt_reg;
        cnt_next  = cnt_reg;
        src_next  = src_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            sqrt_next = ctrl.is_sqrt;
            cnt_next  = ctrl.is_sqrt ? CntW'(SqrtSteps) : CntW'(DivSteps);
            src_next  = src;
            rem_next  = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            rem_next = geq ? diff : rem_sh;
            q_next   = {q_reg[SrcW-2:0], geq};
            src_next = sqrt_reg ? {src_reg[SrcW-3:0], 2'b00} : {src_reg[SrcW-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        sqrt_reg <= sqrt_next;
        src_reg  <= src_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

// ===== src/slip_leg_phase_and_spring_force_unit.sv =====
// slip leg phase tracker and spring force unit, top level
// flight beat: decided at accept, then loaded from the done state once the output slot is free
// stance beat: leg length from the shared restoring unit in 34 root steps, then 84 quotient
// steps per force component; at zero leg length the force divisions are skipped
// one beat in work at a time; s_tready is high only while idle
// rst_n async low: flight, armed, last velocity sign negative, default regs
module slip_leg_phase_and_spring_force_unit
    import slpsf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,   // mass_x, mass_z, mass_vz, foot_x, foot_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // force_x, force_z, foot_target_x
    output logic [2:0]   m_tuser,   // in_stance, place_foot, unstable
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [20:0]  cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQX  = 4'd1;
    localparam logic [3:0] ST_SQZ  = 4'd2;
    localparam logic [3:0] ST_SUM  = 4'd3;
    localparam logic [3:0] ST_SQRT = 4'd4;
    localparam logic [3:0] ST_SPR  = 4'd5;
    localparam logic [3:0] ST_SPW  = 4'd6;
    localparam logic [3:0] ST_P0   = 4'd7;
    localparam logic [3:0] ST_P1   = 4'd8;
    localparam logic [3:0] ST_P2   = 4'd9;
    localparam logic [3:0] ST_DIV  = 4'd10;
    localparam logic [3:0] ST_DONE = 4'd11;

    logic [3:0]      state_reg, state_next;
    logic [CfgW-1:0] l0_reg, td_reg, reach_reg;
    logic [KW-1:0]   k_reg;
    logic            stance_reg, stance_next;
    logic            armed_reg, armed_next;
    logic [1:0]      sign_reg, sign_next;

    logic [32:0]     dx_reg, dx_next, dz_reg, dz_next;
    logic [ProdW-1:0] sqx_reg, sqx_next, plo_reg, plo_next;
    logic [MulW-1:0] len_reg, len_next;
    logic [49:0]     spr_reg, spr_next;
    logic            sneg_reg, sneg_next;
    logic            comp_reg, comp_next;
    logic [WordW-1:0] fx_reg, fx_next, fz_reg, fz_next, tgt_reg, tgt_next;
    logic            place_reg, place_next, unst_reg, unst_next;

    logic            mv_reg, mv_next;
    logic [95:0]     md_reg, md_next;
    logic [2:0]      mu_reg, mu_next;

    logic signed [31:0] in_mx, in_mz, in_vz, in_fx, in_fz;
    logic [1:0]      vsign;
    logic            rearm, armed_eff, touch;
    logic [32:0]     tsum;
    logic [32:0]     ax, az, dsel;
    logic            dneg;
    logic signed [35:0] sdiff;
    logic [35:0]     sdiff_abs;
    logic [MulW-1:0] mul_a, mul_b;
    logic [ProdW-1:0] mul_p;
    rsu_ctrl_t       rsu_ctrl;
    logic [SrcW-1:0] rsu_src, rsu_quo, prod;
    logic            rsu_done;
    logic            cneg, big;
    logic [WordW-1:0] sat;

    assign in_mx = s_tdata[31:0];
    assign in_mz = s_tdata[63:32];
    assign in_vz = s_tdata[95:64];
    assign in_fx = s_tdata[127:96];
    assign in_fz = s_tdata[159:128];

    // flight decision terms
    always_comb
    begin
        if (in_vz > 0)
            vsign = SIGN_POS;
        else if (in_vz < 0)
            vsign = SIGN_NEG;
        else
            vsign = SIGN_ZERO;
        rearm = (vsign != sign_reg) &&
                ($signed({in_mz[31], in_mz}) > $signed({12'b0, reach_reg}));
        armed_eff = armed_reg | rearm;
        touch = (in_vz < 0) &&
                ($signed({in_mz[31], in_mz}) <= $signed({12'b0, td_reg})) && armed_eff;
        tsum = {in_mx[31], in_mx} + {12'b0, reach_reg};
    end

    // magnitudes and spring term
    always_comb
    begin
        ax = dx_reg[32] ? (33'd0 - dx_reg) : dx_reg;
        az = dz_reg[32] ? (33'd0 - dz_reg) : dz_reg;
        dsel = comp_reg ? az : ax;
        dneg = comp_reg ? dz_reg[32] : dx_reg[32];
        sdiff = $signed({15'b0, l0_reg}) - $signed({2'b0, len_reg});
        sdiff_abs = sdiff[35] ? (36'd0 - sdiff) : sdiff;
    end

    // multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_SQX:  begin mul_a = {1'b0, ax}; mul_b = {1'b0, ax}; end
            ST_SQZ:  begin mul_a = {1'b0, az}; mul_b = {1'b0, az}; end
            ST_SPR:  begin mul_a = {18'b0, k_reg}; mul_b = sdiff_abs[MulW-1:0]; end
            ST_P0:   begin mul_a = spr_reg[MulW-1:0]; mul_b = {1'b0, dsel}; end
            ST_P1:   begin mul_a = {18'b0, spr_reg[49:MulW]}; mul_b = {1'b0, dsel}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    slpsf_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // restoring unit feed
    always_comb
    begin
        prod = {16'b0, plo_reg} + {mul_p[49:0], 34'b0};
        rsu_ctrl.start   = (state_reg == ST_SUM) || (state_reg == ST_P2);
        rsu_ctrl.is_sqrt = (state_reg == ST_SUM);
        if (state_reg == ST_SUM)
            rsu_src = {2'b0, {1'b0, sqx_reg[64:0]} + {1'b0, mul_p[64:0]}, 16'b0};
        else
            rsu_src = prod;
    end

    slpsf_rsu u_rsu (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rsu_ctrl),
        .src   (rsu_src),
        .dvsr  (len_reg),
        .done  (rsu_done),
        .quo   (rsu_quo)
    );

    // quotient saturation
    always_comb
    begin
        cneg = sneg_reg ^ dneg;
        big  = |rsu_quo[SrcW-1:40];
        if (cneg)
        begin
            if (big || (rsu_quo[39:0] >= 40'h0080000000))
                sat = 32'h80000000;
            else
                sat = 32'd0 - rsu_quo[31:0];
        end
        else
        begin
            if (big || (rsu_quo[39:0] >= 40'h007FFFFFFF))
                sat = 32'h7FFFFFFF;
            else
                sat = rsu_quo[31:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        stance_next = stance_reg;
        armed_next  = armed_reg;
        sign_next   = sign_reg;
        dx_next     = dx_reg;
        dz_next     = dz_reg;
        sqx_next    = sqx_reg;
        plo_next    = plo_reg;
        len_next    = len_reg;
        spr_next    = spr_reg;
        sneg_next   = sneg_reg;
        comp_next   = comp_reg;
        fx_next     = fx_reg;
        fz_next     = fz_reg;
        tgt_next    = tgt_reg;
        place_next  = place_reg;
        unst_next   = unst_reg;
        mv_next     = mv_reg & ~m_tready;
        md_next     = md_reg;
        mu_next     = mu_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    sign_next  = vsign;
                    fx_next    = '0;
                    fz_next    = '0;
                    tgt_next   = '0;
                    place_next = 1'b0;
                    unst_next  = 1'b0;
                    dx_next    = {in_mx[31], in_mx} - {in_fx[31], in_fx};
                    dz_next    = {in_mz[31], in_mz} - {in_fz[31], in_fz};
                    if (!stance_reg)
                    begin
                        armed_next = armed_eff;
                        state_next = ST_DONE;
                        if (touch)
                        begin
                            place_next  = 1'b1;
                            stance_next = 1'b1;
                            tgt_next    = (!tsum[32] && tsum[31]) ? 32'h7FFFFFFF
                                                                  : tsum[31:0];
                        end
                        else if ($signed({in_mz[31], in_mz}) <
                                 $signed({12'b0, td_reg}))
                        begin
                            unst_next = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = ST_SQX;
                    end
                end
            end
            ST_SQX:  state_next = ST_SQZ;
            ST_SQZ:
            begin
                sqx_next   = mul_p;
                state_next = ST_SUM;
            end
            ST_SUM:  state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (rsu_done)
                begin
                    len_next   = rsu_quo[MulW-1:0];
                    state_next = ST_SPR;
                end
            end
            ST_SPR:
            begin
                sneg_next = sdiff[35];
                comp_next = 1'b0;
                if (len_reg >= {13'b0, l0_reg})
                begin
                    stance_next = 1'b0;
                    armed_next  = 1'b0;
                end
                state_next = (len_reg == '0) ? ST_DONE : ST_SPW;
            end
            ST_SPW:
            begin
                spr_next   = mul_p[49:0];
                state_next = ST_P0;
            end
            ST_P0:   state_next = ST_P1;
            ST_P1:
            begin
                plo_next   = mul_p;
                state_next = ST_P2;
            end
            ST_P2:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (rsu_done)
                begin
                    if (!comp_reg)
                    begin
                        fx_next    = sat;
                        comp_next  = 1'b1;
                        state_next = ST_P0;
                    end
                    else
                    begin
                        fz_next    = sat;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                // load output beat once the slot is free
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    md_next    = {tgt_reg, fz_reg, fx_reg};
                    mu_next    = {unst_reg, place_reg, stance_reg};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l0_reg    <= CfgW'(65536);
            k_reg     <= KW'(25000);
            td_reg    <= CfgW'(62703);
            reach_reg <= CfgW'(19040);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_REST_LEN:  l0_reg    <= cfg_data;
                REG_STIFF:     k_reg     <= cfg_data[KW-1:0];
                REG_TD_HEIGHT: td_reg    <= cfg_data;
                REG_REACH:     reach_reg <= cfg_data;
                default:       l0_reg    <= l0_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            stance_reg <= 1'b0;
            armed_reg  <= 1'b1;
            sign_reg   <= SIGN_NEG;
            comp_reg   <= 1'b0;
            mv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            stance_reg <= stance_next;
            armed_reg  <= armed_next;
            sign_reg   <= sign_next;
            comp_reg   <= comp_next;
            mv_reg     <= mv_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        dx_reg    <= dx_next;
        dz_reg    <= dz_next;
        sqx_reg   <= sqx_next;
        plo_reg   <= plo_next;
        len_reg   <= len_next;
        spr_reg   <= spr_next;
        sneg_reg  <= sneg_next;
        fx_reg    <= fx_next;
        fz_reg    <= fz_next;
        tgt_reg   <= tgt_next;
        place_reg <= place_next;
        unst_reg  <= unst_next;
        md_reg    <= md_next;
        mu_reg    <= mu_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;

endmodule

// ===== src/slpsf_checker.sv =====
// port-level checker for the slip leg unit, bound to the top level
`include "slip_leg_phase_and_spring_force_unit_defines.svh"

module slpsf_checker
    import slpsf_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [95:0]  m_tdata,
    input logic [2:0]   m_tuser
);

    // stalled output beat holds
    `SLPSF_AST_NXT(ast_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output beat changed under stall")

    // touchdown enters stance with no unstable flag
    `SLPSF_AST_IMP(ast_place_stance, clk, rst_n, m_tvalid && m_tuser[1], m_tuser[0] && !m_tuser[2], "touchdown beat not in stance")

    // no force on a touchdown beat
    `SLPSF_AST_IMP(ast_place_noforce, clk, rst_n, m_tvalid && m_tuser[1], m_tdata[63:0] == 64'd0, "force on touchdown beat")

    // unstable only in flight with zero force
    `SLPSF_AST_IMP(ast_unst_flight, clk, rst_n, m_tvalid && m_tuser[2], !m_tuser[0] && (m_tdata[63:0] == 64'd0), "unstable beat in stance")

    // one beat in work at a time
    `SLPSF_AST_NXT(ast_one_beat, clk, rst_n, s_tvalid && s_tready, !s_tready, "second beat taken while busy")

endmodule

bind slip_leg_phase_and_spring_force_unit slpsf_checker u_slpsf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
